/* rtl/core/lpd_pkg.sv */
// Shared types and constants for the length-prefix deframer.
// No dependencies; every module in rtl/core imports this package.
package lpd_pkg;

  localparam int LPD_BYTE_W            = 8;
  localparam int LPD_LEN_W             = 32;
  localparam int LPD_HCNT_W            = 2;
  localparam int LPD_HEADER_BYTES      = 4;
  localparam logic [LPD_LEN_W-1:0] LPD_MAX_PAYLOAD_RESET = LPD_LEN_W'(16 * 1024 * 1024);

  typedef struct packed {
    logic [LPD_BYTE_W-1:0] rx_byte;
  } lpd_rx_item_t;

  typedef struct packed {
    logic [LPD_BYTE_W-1:0] payload_byte;
    logic                  frame_start;
    logic                  frame_end;
    logic [LPD_LEN_W-1:0]  frame_len;
    logic                  empty_frame;
    logic                  oversize_drop;
  } lpd_frame_item_t;

endpackage

/* rtl/core/lpd_stream_if.sv */
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is set at instantiation.
interface lpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/lpd_in_stage.sv */
// Input register of the deframer: captures one received byte per transfer.
// Depends on lpd_pkg.
module lpd_in_stage import lpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [LPD_BYTE_W-1:0] in_byte,
  output logic                  in_ready,
  output logic                  item_valid,
  output logic [LPD_BYTE_W-1:0] item_byte,
  input  logic                  item_take
);
  logic                  valid;
  logic [LPD_BYTE_W-1:0] data;

  assign in_ready   = !valid || item_take;
  assign item_valid = valid;
  assign item_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_byte;
    end
  end
endmodule

/* rtl/core/lpd_parser.sv */
// Header gathering, length check and payload tracking for the deframer.
// Depends on lpd_pkg; sits between lpd_in_stage and lpd_out_stage.
module lpd_parser import lpd_pkg::*; #(
  parameter int HEADER_BYTES = LPD_HEADER_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LPD_LEN_W-1:0]  cfg_wdata,
  input  logic                  item_valid,
  input  logic [LPD_BYTE_W-1:0] item_byte,
  output logic                  item_take,
  input  logic                  res_ready,
  output logic                  res_valid,
  output lpd_frame_item_t       res
);
  logic [LPD_LEN_W-1:0]  max_len;
  logic [LPD_HCNT_W-1:0] header_count, header_count_next;
  logic                  in_payload, in_payload_next;
  logic [LPD_LEN_W-1:0]  length_shift, length_shift_next;
  logic [LPD_LEN_W-1:0]  bytes_remaining, bytes_remaining_next;
  logic                  first_pending, first_pending_next;
  logic [LPD_LEN_W-1:0]  shifted;
  logic [LPD_HCNT_W:0]   count_inc;
  logic                  emit;

  assign item_take = item_valid && res_ready;
  assign res_valid = item_take && emit;
  assign shifted   = {length_shift[LPD_LEN_W-LPD_BYTE_W-1:0], item_byte};
  assign count_inc = {1'b0, header_count} + (LPD_HCNT_W+1)'(1);

  always_comb begin
    header_count_next    = header_count;
    in_payload_next      = in_payload;
    length_shift_next    = length_shift;
    bytes_remaining_next = bytes_remaining;
    first_pending_next   = first_pending;
    emit                 = 1'b0;
    res                  = '0;
    if (in_payload) begin
      emit             = 1'b1;
      res.payload_byte = item_byte;
      res.frame_start  = first_pending;
      res.frame_end    = (bytes_remaining <= LPD_LEN_W'(1));
      res.frame_len    = first_pending ? length_shift : '0;
      first_pending_next = 1'b0;
      if (bytes_remaining <= LPD_LEN_W'(1)) begin
        // last byte of the frame: back to header phase
        bytes_remaining_next = '0;
        in_payload_next      = 1'b0;
        length_shift_next    = '0;
      end else begin
        bytes_remaining_next = bytes_remaining - LPD_LEN_W'(1);
      end
    end else if (count_inc < (LPD_HCNT_W+1)'(HEADER_BYTES)) begin
      length_shift_next = shifted;
      header_count_next = count_inc[LPD_HCNT_W-1:0];
    end else begin
      header_count_next = '0;
      length_shift_next = shifted;
      if (shifted > max_len) begin
        // drop the header only
        emit              = 1'b1;
        res.frame_len     = shifted;
        res.oversize_drop = 1'b1;
        length_shift_next = '0;
      end else if (shifted == '0) begin
        emit            = 1'b1;
        res.frame_start = 1'b1;
        res.frame_end   = 1'b1;
        res.empty_frame = 1'b1;
      end else begin
        in_payload_next      = 1'b1;
        bytes_remaining_next = shifted;
        first_pending_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len         <= LPD_MAX_PAYLOAD_RESET;
      header_count    <= '0;
      in_payload      <= 1'b0;
      length_shift    <= '0;
      bytes_remaining <= '0;
      first_pending   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (item_take) begin
        header_count    <= header_count_next;
        in_payload      <= in_payload_next;
        length_shift    <= length_shift_next;
        bytes_remaining <= bytes_remaining_next;
        first_pending   <= first_pending_next;
      end
    end
  end

  a_payload_no_header: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> header_count == '0)
    else $error("header count nonzero during payload");

  a_payload_remaining: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> bytes_remaining != '0)
    else $error("payload phase with no bytes remaining");

  a_first_in_payload: assert property (@(posedge clk) disable iff (rst)
    first_pending |-> in_payload)
    else $error("first-byte flag outside payload phase");

  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    item_take && in_payload |=> !first_pending)
    else $error("first-byte flag survived a payload byte");

  a_drop_not_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.oversize_drop |-> !res.frame_start && !res.frame_end)
    else $error("oversize drop marked as frame boundary");
endmodule

/* rtl/core/lpd_out_stage.sv */
// Result register of the deframer: holds one result until the sink takes it.
// Depends on lpd_pkg.
module lpd_out_stage import lpd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  input  lpd_frame_item_t res,
  output logic            res_ready,
  output logic            out_valid,
  output lpd_frame_item_t out_item,
  input  logic            out_ready
);
  logic            valid;
  lpd_frame_item_t data;

  assign res_ready = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data <= res;
    end
  end
endmodule

/* rtl/core/length_prefix_deframer_core.sv */
// Length-prefix deframer: one received byte per cycle while tx is not stalled, in both directions.
// An rx byte is registered in the input stage; the parser turns it into a result that is
// registered in the output stage for tx; bytes that finish no result leave nothing.
// The parser between the two registers is combinational.
// Synchronous reset clears both stage valids, the parser state and sets the max
// length register to 16 MiB. Depends on lpd_pkg, lpd_stream_if and the lpd_* stages.
module length_prefix_deframer_core import lpd_pkg::*; #(
  parameter int HEADER_BYTES = LPD_HEADER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  lpd_stream_if.sink           rx,
  lpd_stream_if.source         tx,
  input  logic                 cfg_we,
  input  logic [LPD_LEN_W-1:0] cfg_wdata
);
  logic                  item_valid;
  logic [LPD_BYTE_W-1:0] item_byte;
  logic                  item_take;
  logic                  res_ready;
  logic                  res_valid;
  lpd_frame_item_t       res;
  lpd_frame_item_t       out_item;

  lpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_byte    (rx.payload.rx_byte),
    .in_ready   (rx.ready),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_take  (item_take)
  );

  lpd_parser #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  lpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (tx.valid),
    .out_item  (out_item),
    .out_ready (tx.ready)
  );

  assign tx.payload = out_item;
endmodule

/* tb/tb.sv */
// Self-checking testbench for length_prefix_deframer_core: byte stream in, frame marks out.
// Depends on lpd_pkg and lpd_stream_if from rtl/core; carries its own deframing predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpd_pkg::*;

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_BYTES  = 130;
  localparam int SMALL_MAX    = 64;
  localparam logic [LPD_LEN_W-1:0] LEN_ALL_ONES = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [LPD_LEN_W-1:0] cfg_wdata = '0;

  lpd_stream_if #(.payload_t(lpd_rx_item_t))    rx_ch ();
  lpd_stream_if #(.payload_t(lpd_frame_item_t)) tx_ch ();

  length_prefix_deframer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .tx        (tx_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Deframing predictor state
  logic [LPD_HCNT_W-1:0] hdr_cnt = '0;
  bit                    in_pl = 1'b0;
  bit                    first_pend = 1'b0;
  logic [LPD_LEN_W-1:0]  len_acc = '0;
  logic [LPD_LEN_W-1:0]  remaining = '0;
  logic [LPD_LEN_W-1:0]  max_len = LPD_MAX_PAYLOAD_RESET;
  lpd_frame_item_t       expected_frames[$];

  // Traffic shaping and bookkeeping
  bit tx_gap_on = 1'b1;
  bit rx_stall_on = 1'b1;
  int rx_hold_left = 0;
  int bytes_sent = 0;
  int settings_count = 0;
  int frames_seen = 0;
  int empties_seen = 0;
  int drops_seen = 0;
  int mismatch_count = 0;
  longint cycle_count = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string fmt_frame(lpd_frame_item_t f);
    return $sformatf("byte=%02h start=%0b end=%0b len=%08h empty=%0b drop=%0b",
                     f.payload_byte, f.frame_start, f.frame_end, f.frame_len,
                     f.empty_frame, f.oversize_drop);
  endfunction

  // Append one expected result at the tail of the queue.
  task automatic queue_expected(input lpd_frame_item_t r);
    expected_frames = {expected_frames, r};
  endtask

  // Advance the deframer by one received byte and queue what it must produce.
  task automatic deframe_byte(input logic [LPD_BYTE_W-1:0] b);
    lpd_frame_item_t r;
    r = '0;
    if (in_pl) begin
      r.payload_byte = b;
      r.frame_start  = first_pend;
      r.frame_end    = (remaining <= 1);
      r.frame_len    = first_pend ? len_acc : '0;
      first_pend = 1'b0;
      if (remaining > 0) remaining = remaining - 1;
      if (remaining == 0) begin
        in_pl   = 1'b0;
        len_acc = '0;
      end
      queue_expected(r);
    end else begin
      len_acc = {len_acc[LPD_LEN_W-LPD_BYTE_W-1:0], b};
      if (int'(hdr_cnt) + 1 < LPD_HEADER_BYTES) begin
        hdr_cnt = hdr_cnt + 1'b1;
      end else begin
        hdr_cnt = '0;
        if (len_acc > max_len) begin
          r.frame_len     = len_acc;
          r.oversize_drop = 1'b1;
          len_acc = '0;
          queue_expected(r);
        end else if (len_acc == 0) begin
          r.frame_start = 1'b1;
          r.frame_end   = 1'b1;
          r.empty_frame = 1'b1;
          queue_expected(r);
        end else begin
          in_pl      = 1'b1;
          remaining  = len_acc;
          first_pend = 1'b1;
        end
      end
    end
  endtask

  // Offer one byte after an optional gap; return at the edge of its transfer.
  task automatic send_byte(input logic [LPD_BYTE_W-1:0] b);
    int gap;
    lpd_rx_item_t item;
    gap = tx_gap_on ? pick_gap() : 0;
    item.rx_byte = b;
    @(negedge clk);
    if (gap > 0) begin
      rx_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.payload = item;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_header(input logic [LPD_LEN_W-1:0] len);
    for (int i = LPD_HEADER_BYTES - 1; i >= 0; i--)
      send_byte(len[i*LPD_BYTE_W +: LPD_BYTE_W]);
  endtask

  task automatic send_frame(input logic [LPD_LEN_W-1:0] len);
    send_header(len);
    repeat (len) send_byte(LPD_BYTE_W'($urandom_range(0, 255)));
  endtask

  // Feed filler bytes until the stream sits on a header boundary again.
  task automatic resync();
    while (hdr_cnt != 0 || in_pl) send_byte(LPD_BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    // header bytes leave no result but may still sit in the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [LPD_LEN_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    max_len   = v;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_count++;
  endtask

  // Receiver: drive ready with stalls and holds, check each transfer.
  initial begin
    lpd_frame_item_t got;
    lpd_frame_item_t want;
    int stall_left;
    stall_left   = 0;
    tx_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        tx_ch.ready = 1'b0;
        rx_hold_left--;
      end else if (stall_left > 0) begin
        tx_ch.ready = 1'b0;
        stall_left--;
      end else begin
        tx_ch.ready = 1'b1;
        stall_left  = rx_stall_on ? pick_gap() : 0;
      end
      @(posedge clk);
      if (!rst && tx_ch.valid && tx_ch.ready) begin
        got = tx_ch.payload;
        if (got.frame_start && !got.empty_frame) frames_seen++;
        if (got.empty_frame) empties_seen++;
        if (got.oversize_drop) drops_seen++;
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing expected: %s", $realtime, fmt_frame(got));
        end else begin
          want = expected_frames.pop_front();
          if (got.payload_byte !== want.payload_byte || got.frame_start !== want.frame_start ||
              got.frame_end !== want.frame_end || got.frame_len !== want.frame_len ||
              got.empty_frame !== want.empty_frame ||
              got.oversize_drop !== want.oversize_drop) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch\n  expected %s\n  actual   %s",
                       $realtime, fmt_frame(want), fmt_frame(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_frames.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Reset value of the limit: one above 16 MiB drops, empty and short frames pass.
  task automatic test_reset_limit();
    send_header(LPD_MAX_PAYLOAD_RESET + 1);
    send_header('0);
    send_header(2);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Boundaries of the limit register: equal passes, one more drops.
  task automatic test_limit_edges();
    write_max('0);
    send_header(1);
    write_max(5);
    send_frame(5);
    send_header(6);
    write_max(LEN_ALL_ONES - 1);
    send_header(LEN_ALL_ONES);
    write_max(LEN_ALL_ONES);
    send_frame(1);
  endtask

  // Hold the output off long enough that the input stalls too.
  task automatic test_output_stall();
    tx_gap_on   = 1'b0;
    rx_stall_on = 1'b0;
    drain();
    rx_hold_left = 300;
    send_frame(60);
    drain();
    tx_gap_on   = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [LPD_LEN_W-1:0] limits[7];
    logic [LPD_LEN_W-1:0] cap;
    logic [LPD_LEN_W-1:0] len;
    int stop_at;
    int sel;
    limits = '{LPD_MAX_PAYLOAD_RESET, '0, 3, $urandom_range(1, SMALL_MAX), LEN_ALL_ONES,
               $urandom, 32'h8000_0000};
    foreach (limits[p]) begin
      write_max(limits[p]);
      tx_gap_on   = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      cap = (max_len < 200) ? max_len : 200;
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        sel = $urandom_range(0, 99);
        if (sel < 70 || max_len == LEN_ALL_ONES) begin
          if ($urandom_range(0, 4) == 0) len = $urandom_range(0, cap);
          else len = $urandom_range(0, (cap < 12) ? cap : 12);
          send_frame(len);
        end else if (sel < 88 || max_len > SMALL_MAX) begin
          // oversize header, often right at the boundary
          if ($urandom_range(0, 1) == 0) send_header(max_len + 1);
          else send_header($urandom_range(max_len + 1, LEN_ALL_ONES));
        end else begin
          // noise: random bytes out of frame alignment
          repeat ($urandom_range(1, 5)) send_byte(LPD_BYTE_W'($urandom_range(0, 255)));
          resync();
        end
      end
      resync();
    end
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.payload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_limit();
    test_limit_edges();
    test_output_stall();
    test_random_traffic();

    drain();
    if (expected_frames.size() != 0) mismatch_count++;
    $display("covered %0d bytes over %0d limit settings, including a long output hold",
             bytes_sent, settings_count + 1);
    $display("results: %0d frames, %0d empty frames, %0d oversize drops",
             frames_seen, empties_seen, drops_seen);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
